// ----- design/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared types and constants of the bilinear height sampler.
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
  localparam int unsigned NUM_TAPS    = 4;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd2;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } wr_req_t;

endpackage

// ----- design/bilinear_height_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_height_sampler
// Wrapped bilinear height-map sampler with a texel store filled by writes.
// A sample result passes through stages 1 to 7 and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the four taps read four store copies.
// A write passes through stages 1 to 3 and is written into the store from stage 3.
// Reset clears valid bits and sets map_enabled=0, width=height=256 (saturated).
// The store has no reset; texels are defined once written.
// ----------------------------------------------------------------------------
module bilinear_height_sampler #(
  parameter int unsigned MAX_WIDTH   = 256,
  parameter int unsigned MAX_HEIGHT  = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bhs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bhs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [bhs_pkg::ADDR_W-1:0]          texel_index_i,
  input  logic [bhs_pkg::HEIGHT_W-1:0]        texel_value_i,
  input  logic signed [bhs_pkg::COORD_W-1:0]  u_coord_i,
  input  logic signed [bhs_pkg::COORD_W-1:0]  v_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bhs_pkg::HEIGHT_W-1:0]        sampled_height_o,
  output logic                                map_missing_o
);
  import bhs_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = SAMPLE_BITS;
  localparam int unsigned PXW = $clog2(MAX_WIDTH);
  localparam int unsigned PYW = $clog2(MAX_HEIGHT);
  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SUW = F + PXW;
  localparam int unsigned SVW = F + PYW;
  localparam int unsigned RPW = PYW + WB;
  localparam int unsigned RMW = (RPW > ADDR_W) ? RPW : ADDR_W;
  localparam int unsigned VMX = (SW > HEIGHT_W) ? SW : HEIGHT_W;
  localparam int unsigned PRW = SW + F + 2;
  localparam logic [WB-1:0] W_RST = WB'((256 > MAX_WIDTH) ? MAX_WIDTH : 256);
  localparam logic [HB-1:0] H_RST = HB'((256 > MAX_HEIGHT) ? MAX_HEIGHT : 256);

  function automatic int eff_size(logic [CFG_DATA_W-1:0] v, int mx);
    int r;
    r = int'(v);
    if (v == '0) begin
      r = 1;
    end else if (r > mx) begin
      r = mx;
    end
    return r;
  endfunction

  function automatic logic signed [PRW-1:0] blend_mul(logic [SW-1:0] a, logic [SW-1:0] b,
                                                      logic [F-1:0] t);
    logic signed [SW:0] d;
    logic signed [F:0]  ts;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    ts = $signed({1'b0, t});
    return PRW'(d) * PRW'(ts);
  endfunction

  function automatic logic [SW-1:0] blend_add(logic [SW-1:0] a, logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] s;
    s = $signed(PRW'(a)) + (p >>> F);
    return s[SW-1:0];
  endfunction

  // configuration
  logic          map_enabled_q;
  logic [WB-1:0] map_w_q;
  logic [HB-1:0] map_h_q;
  logic [PXW-1:0] wm1;
  logic [PYW-1:0] hm1;

  assign cfg_ready_o = 1'b1;
  assign wm1 = PXW'(map_w_q - 1'b1);
  assign hm1 = PYW'(map_h_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_enabled_q <= 1'b0;
      map_w_q       <= W_RST;
      map_h_q       <= H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_ENABLED: map_enabled_q <= cfg_data_i[0];
        CFG_MAP_WIDTH:   map_w_q <= WB'(eff_size(cfg_data_i, int'(MAX_WIDTH)));
        CFG_MAP_HEIGHT:  map_h_q <= HB'(eff_size(cfg_data_i, int'(MAX_HEIGHT)));
        default: ;
      endcase
    end
  end

  // pipeline control
  logic out_valid_q;
  logic adv;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: wrap and scale coordinates
  logic [VMX-1:0] val_ext;
  logic [SUW-1:0] su_d;
  logic [SVW-1:0] sv_d;

  assign val_ext = VMX'(texel_value_i);
  assign su_d    = SUW'(u_coord_i[F-1:0]) * SUW'(wm1);
  assign sv_d    = SVW'(v_coord_i[F-1:0]) * SVW'(hm1);

  logic              s1_vld_q;
  cmd_e              s1_cmd_q;
  logic [ADDR_W-1:0] s1_idx_q;
  logic [SW-1:0]     s1_val_q;
  logic [SUW-1:0]    s1_su_q;
  logic [SVW-1:0]    s1_sv_q;

  // stage 2: positions, clamped neighbors, row bases
  logic [PXW-1:0] x0, x1;
  logic [PYW-1:0] y0, y1;
  logic [RMW-1:0] row0_full, row1_full;

  assign x0 = s1_su_q[SUW-1:F];
  assign y0 = s1_sv_q[SVW-1:F];
  assign x1 = (x0 == wm1) ? wm1 : x0 + 1'b1;
  assign y1 = (y0 == hm1) ? hm1 : y0 + 1'b1;
  assign row0_full = RMW'(y0) * RMW'(map_w_q);
  assign row1_full = RMW'(y1) * RMW'(map_w_q);

  logic              s2_vld_q;
  cmd_e              s2_cmd_q;
  logic [ADDR_W-1:0] s2_idx_q;
  logic [SW-1:0]     s2_val_q;
  logic [PXW-1:0]    s2_x0_q, s2_x1_q;
  logic [ADDR_W-1:0] s2_row0_q, s2_row1_q;
  logic [F-1:0]      s2_fx_q, s2_fy_q;

  // stage 3: tap addresses
  logic              s3_vld_q;
  cmd_e              s3_cmd_q;
  logic [ADDR_W-1:0] s3_idx_q;
  logic [SW-1:0]     s3_val_q;
  logic [ADDR_W-1:0] s3_addr_q [NUM_TAPS];
  logic [F-1:0]      s3_fx_q, s3_fy_q;

  // stage 4: store read and write
  wr_req_t       wr_req;
  logic [SW-1:0] tex [NUM_TAPS];
  logic          s4_smp_q;
  logic [F-1:0]  s4_fx_q, s4_fy_q;

  assign wr_req.en   = adv && s3_vld_q && (s3_cmd_q == CMD_WRITE);
  assign wr_req.addr = s3_idx_q;

  bhs_texel_store #(
    .DATA_W (SW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .wr_data_i (s3_val_q),
    .rd_en_i   (adv),
    .rd_addr_i (s3_addr_q),
    .rd_data_o (tex)
  );

  // stage 5..8: horizontal then vertical blend
  logic                  s5_vld_q;
  logic signed [PRW-1:0] s5_pt_q, s5_pb_q;
  logic [SW-1:0]         s5_a0_q, s5_a2_q;
  logic [F-1:0]          s5_fy_q;

  logic                  s6_vld_q;
  logic [SW-1:0]         s6_top_q, s6_bot_q;
  logic [F-1:0]          s6_fy_q;

  logic                  s7_vld_q;
  logic signed [PRW-1:0] s7_pv_q;
  logic [SW-1:0]         s7_top_q;

  logic [SW-1:0]         res;
  logic [VMX-1:0]        res_ext;
  logic [HEIGHT_W-1:0]   out_height_q;
  logic                  out_missing_q;

  assign res     = blend_add(s7_top_q, s7_pv_q);
  assign res_ext = VMX'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_smp_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      s7_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_smp_q    <= s3_vld_q && (s3_cmd_q == CMD_SAMPLE);
      s5_vld_q    <= s4_smp_q;
      s6_vld_q    <= s5_vld_q;
      s7_vld_q    <= s6_vld_q;
      out_valid_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q <= cmd_e'(command_i);
      s1_idx_q <= texel_index_i;
      s1_val_q <= val_ext[SW-1:0];
      s1_su_q  <= su_d;
      s1_sv_q  <= sv_d;

      s2_cmd_q  <= s1_cmd_q;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_x0_q   <= x0;
      s2_x1_q   <= x1;
      s2_row0_q <= row0_full[ADDR_W-1:0];
      s2_row1_q <= row1_full[ADDR_W-1:0];
      s2_fx_q   <= s1_su_q[F-1:0];
      s2_fy_q   <= s1_sv_q[F-1:0];

      s3_cmd_q     <= s2_cmd_q;
      s3_idx_q     <= s2_idx_q;
      s3_val_q     <= s2_val_q;
      s3_addr_q[0] <= s2_row0_q + ADDR_W'(s2_x0_q);
      s3_addr_q[1] <= s2_row0_q + ADDR_W'(s2_x1_q);
      s3_addr_q[2] <= s2_row1_q + ADDR_W'(s2_x0_q);
      s3_addr_q[3] <= s2_row1_q + ADDR_W'(s2_x1_q);
      s3_fx_q      <= s2_fx_q;
      s3_fy_q      <= s2_fy_q;

      s4_fx_q <= s3_fx_q;
      s4_fy_q <= s3_fy_q;

      s5_pt_q <= blend_mul(tex[0], tex[1], s4_fx_q);
      s5_pb_q <= blend_mul(tex[2], tex[3], s4_fx_q);
      s5_a0_q <= tex[0];
      s5_a2_q <= tex[2];
      s5_fy_q <= s4_fy_q;

      s6_top_q <= blend_add(s5_a0_q, s5_pt_q);
      s6_bot_q <= blend_add(s5_a2_q, s5_pb_q);
      s6_fy_q  <= s5_fy_q;

      s7_pv_q  <= blend_mul(s6_top_q, s6_bot_q, s6_fy_q);
      s7_top_q <= s6_top_q;

      out_height_q  <= map_enabled_q ? res_ext[HEIGHT_W-1:0] : '0;
      out_missing_q <= !map_enabled_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sampled_height_o = out_height_q;
  assign map_missing_o    = out_missing_q;

`ifndef ASSERT_OFF
  a_missing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && map_missing_o |-> sampled_height_o == '0)
    else $error("disabled map answered with a nonzero height");

  a_last_stage_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s7_vld_q && !in_stall_o |=> out_valid_o)
    else $error("sample lost between last blend stage and output");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s7_vld_q && !in_stall_o |=> !out_valid_o)
    else $error("result shown without a sample behind it");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(s4_smp_q) && $stable(s7_vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ----- design/bhs_texel_store.sv -----
// ----------------------------------------------------------------------------
// bhs_texel_store
// Height store kept as one copy per bilinear tap: every write goes to all
// copies, each copy serves one registered read per cycle while rd_en_i is high.
// ----------------------------------------------------------------------------
module bhs_texel_store #(
  parameter int unsigned DATA_W = 16
) (
  input  logic                        clk_i,
  input  bhs_pkg::wr_req_t            wr_i,
  input  logic [DATA_W-1:0]           wr_data_i,
  input  logic                        rd_en_i,
  input  logic [bhs_pkg::ADDR_W-1:0]  rd_addr_i [bhs_pkg::NUM_TAPS],
  output logic [DATA_W-1:0]           rd_data_o [bhs_pkg::NUM_TAPS]
);
  import bhs_pkg::*;

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_copy
    logic [DATA_W-1:0] mem_q [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en) begin
        mem_q[wr_i.addr] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_data_q <= mem_q[rd_addr_i[g]];
      end
    end

    assign rd_data_o[g] = rd_data_q;
  end

endmodule

// ----- bench/bhs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bhs_checker
// Watches the configuration, sample and result channels of the bilinear
// height sampler. It keeps its own texel store and map settings, works out
// the height each sample transaction must return, and compares every result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bhs_checker
  import bhs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  command_i,
  input  logic [ADDR_W-1:0]     texel_index_i,
  input  logic [HEIGHT_W-1:0]   texel_value_i,
  input  logic [COORD_W-1:0]    u_coord_i,
  input  logic [COORD_W-1:0]    v_coord_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [HEIGHT_W-1:0]   sampled_height_i,
  input  logic                  map_missing_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAP_MAX = 256;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                missing;
  } height_rec_t;

  logic                  map_enabled_q;
  logic [CFG_DATA_W-1:0] map_width_q;
  logic [CFG_DATA_W-1:0] map_height_q;
  logic [HEIGHT_W-1:0]   height_mem [STORE_DEPTH];
  height_rec_t           expected_q [$];

  function automatic logic [8:0] used_size(logic [CFG_DATA_W-1:0] s);
    if (s == '0) return 9'd1;
    if (s > MAP_MAX) return 9'(MAP_MAX);
    return 9'(s);
  endfunction

  function automatic void locate_axis(input logic [15:0] frac_in, input logic [8:0] size,
                                      output logic [8:0] p0, output logic [8:0] p1,
                                      output logic [15:0] frac);
    logic [24:0] scaled;
    scaled = frac_in * (size - 9'd1);
    p0     = scaled[24:16];
    p1     = (p0 == size - 9'd1) ? p0 : p0 + 9'd1;
    frac   = scaled[15:0];
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] t);
    logic [33:0] acc;
    acc = a * (17'h10000 - t) + b * t;
    return acc[31:16];
  endfunction

  function automatic logic [15:0] texel_at(logic [8:0] x, logic [8:0] y, logic [8:0] w);
    logic [ADDR_W-1:0] addr;
    addr = y * w + x;
    return height_mem[addr];
  endfunction

  function automatic logic [15:0] predict_height(logic [15:0] u_frac, logic [15:0] v_frac);
    logic [8:0]  w, h, x0, x1, y0, y1;
    logic [15:0] fx, fy, top_row, bottom_row;
    w = used_size(map_width_q);
    h = used_size(map_height_q);
    locate_axis(u_frac, w, x0, x1, fx);
    locate_axis(v_frac, h, y0, y1, fy);
    top_row    = blend(texel_at(x0, y0, w), texel_at(x1, y0, w), fx);
    bottom_row = blend(texel_at(x0, y1, w), texel_at(x1, y1, w), fx);
    return blend(top_row, bottom_row, fy);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    height_rec_t want;
    if (!rst_ni) begin
      map_enabled_q    = 1'b0;
      map_width_q      = 9'd256;
      map_height_q     = 9'd256;
      expected_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("sampled_height: result with no pending sample, expected none, got %0d",
                 sampled_height_i);
          mismatch_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (sampled_height_i !== want.height) begin
            $error("sampled_height: expected %0d, got %0d", want.height, sampled_height_i);
            mismatch_count_o++;
          end
          if (map_missing_i !== want.missing) begin
            $error("map_missing: expected %0d, got %0d", want.missing, map_missing_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAP_ENABLED: map_enabled_q = cfg_data_i[0];
          CFG_MAP_WIDTH:   map_width_q   = cfg_data_i;
          CFG_MAP_HEIGHT:  map_height_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_e'(command_i) == CMD_WRITE) begin
          height_mem[texel_index_i] = texel_value_i;
        end else if (!map_enabled_q) begin
          want.height  = '0;
          want.missing = 1'b1;
          expected_q.push_back(want);
        end else begin
          want.height  = predict_height(u_coord_i[15:0], v_coord_i[15:0]);
          want.missing = 1'b0;
          expected_q.push_back(want);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bilinear height sampler. Writes every texel
// that a sample reads before that sample, runs directed corner samples
// and then random write and sample traffic over several map settings, with
// random idle cycles on both channels in most phases. The checker beside
// the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import bhs_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned CFG_SETTLE   = 12;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 20;
  localparam int unsigned MAP_MAX      = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        command;
  logic [ADDR_W-1:0]           texel_index;
  logic [HEIGHT_W-1:0]         texel_value;
  logic signed [COORD_W-1:0]   u_coord;
  logic signed [COORD_W-1:0]   v_coord;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [HEIGHT_W-1:0]         sampled_height;
  logic                        map_missing;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  bit          texel_written [STORE_DEPTH];

  bilinear_height_sampler dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .texel_index_i    (texel_index),
    .texel_value_i    (texel_value),
    .u_coord_i        (u_coord),
    .v_coord_i        (v_coord),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .sampled_height_o (sampled_height),
    .map_missing_o    (map_missing)
  );

  bhs_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .texel_index_i    (texel_index),
    .texel_value_i    (texel_value),
    .u_coord_i        (u_coord),
    .v_coord_i        (v_coord),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sampled_height_i (sampled_height),
    .map_missing_i    (map_missing),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAP_MAX) return MAP_MAX;
    return 32'(s);
  endfunction

  function automatic int unsigned axis_pos(logic [COORD_W-1:0] c, int unsigned size);
    return (32'(c[15:0]) * (size - 1)) >> 16;
  endfunction

  function automatic logic [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c[31:16] = 16'($urandom);
    case ($urandom_range(5))
      0:       c[15:0] = 16'h0000;
      1:       c[15:0] = 16'hFFFF;
      2:       c[15:0] = 16'h8000;
      default: c[15:0] = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_item(cmd_e cmd, logic [ADDR_W-1:0] idx, logic [HEIGHT_W-1:0] val,
                           logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    command     = cmd;
    texel_index = idx;
    texel_value = val;
    u_coord     = u;
    v_coord     = v;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_WRITE) texel_written[idx] = 1'b1;
  endtask

  task automatic write_texel(logic [ADDR_W-1:0] idx, logic [HEIGHT_W-1:0] val);
    send_item(CMD_WRITE, idx, val, $urandom, $urandom);
  endtask

  task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    send_item(CMD_SAMPLE, ADDR_W'($urandom), HEIGHT_W'($urandom), u, v);
  endtask

  task automatic cover_texel(int unsigned a);
    if (!texel_written[a]) write_texel(ADDR_W'(a), rand_height());
  endtask

  // write those of the four taps of a random sample not yet written, then send the sample
  task automatic sample_mapped(int unsigned w, int unsigned h);
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    int unsigned        x0, x1, y0, y1;
    u  = rand_coord();
    v  = rand_coord();
    x0 = axis_pos(u, w);
    y0 = axis_pos(v, h);
    x1 = (x0 + 1 < w) ? x0 + 1 : x0;
    y1 = (y0 + 1 < h) ? y0 + 1 : y0;
    cover_texel((y0 * w + x0) & (STORE_DEPTH - 1));
    cover_texel((y0 * w + x1) & (STORE_DEPTH - 1));
    cover_texel((y1 * w + x0) & (STORE_DEPTH - 1));
    cover_texel((y1 * w + x1) & (STORE_DEPTH - 1));
    sample_at(u, v);
  endtask

  // hold the sender until every outstanding result is back, then let writes land
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_map(logic en, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    write_cfg(CFG_MAP_ENABLED, {8'($urandom), en});
    write_cfg(CFG_MAP_WIDTH, w);
    write_cfg(CFG_MAP_HEIGHT, h);
  endtask

  task automatic run_phase(logic en, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned region;
    int unsigned pick;
    w_eff  = eff_dim(w);
    h_eff  = eff_dim(h);
    region = w_eff * h_eff;
    settle();
    load_map(en, w, h);
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(39) == 0) settle();
      pick = $urandom_range(99);
      if (pick < 25) write_texel(ADDR_W'($urandom_range(region - 1)), rand_height());
      else if (pick < 35) write_texel(ADDR_W'($urandom), rand_height());
      else if (en) sample_mapped(w_eff, h_eff);
      else sample_at(rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    command       = 1'b0;
    texel_index   = '0;
    texel_value   = '0;
    u_coord       = '0;
    v_coord       = '0;
    send_idle_pct = 9;
    recv_idle_pct = 54;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // map disabled after reset; writes still land in the store
    sample_at(32'h0000_0000, 32'h0000_0000);
    write_texel(16'd0, 16'h0000);
    write_texel(16'd1, 16'hFFFF);
    write_texel(16'd2, 16'h8000);
    write_texel(16'd3, 16'h0001);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    settle();
    write_cfg(CFG_SPARE, 9'h1FF);
    load_map(1'b1, 9'd2, 9'd2);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0000_FFFF, 32'h0000_FFFF);
    sample_at(32'hFFFF_FFFF, 32'h8000_0000);
    sample_at(32'h7FFF_FFFF, 32'h0000_8000);
    sample_at(32'h0001_8000, 32'hFFFF_8000);
    // sample right behind a write to a texel it reads
    write_texel(16'd3, 16'hFFFF);
    sample_at(32'h0000_FFFF, 32'h0000_FFFF);
    write_texel(16'd0, 16'h1234);
    sample_at(32'h0000_0000, 32'h0000_0000);
    settle();
    load_map(1'b1, 9'd0, 9'd0);
    sample_at(32'h0000_FFFF, 32'hFFFF_0001);
    sample_at($urandom, $urandom);

    run_phase(1'b1, 9'd8, 9'd4);
    run_phase(1'b1, 9'd1, 9'd256);
    run_phase(1'b1, 9'd256, 9'd1);

    send_idle_pct = 54;
    recv_idle_pct = 9;
    run_phase(1'b0, 9'd13, 9'd7);
    run_phase(1'b1, 9'd0, 9'd5);
    run_phase(1'b1, 9'($urandom_range(2, 32)), 9'($urandom_range(2, 32)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b1, 9'd511, 9'd300);
    run_phase(1'b1, 9'd256, 9'd256);
    run_phase(1'b1, 9'($urandom_range(1, 64)), 9'($urandom_range(1, 64)));

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- bilinear_height_sampler.f -----
design/bhs_pkg.sv
design/bhs_texel_store.sv
design/bilinear_height_sampler.sv
bench/bhs_checker.sv
bench/tb.sv
